[rtl/icsp_pkg.sv]
`timescale 1ns / 1ps

package icsp_pkg;

  localparam int CFG_HALF_W   = 8;
  localparam int CFG_WAIT_W   = 20;
  localparam int CFG_KEY_W    = 32;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 5;
  localparam int REG_IDX_W    = 3;

  localparam int CMD_BITS         = 4;
  localparam int READ_BITS        = 8;
  localparam int READ_FRAME_BITS  = 12;
  localparam int WRITE_FRAME_BITS = 20;

  localparam logic [REG_IDX_W-1:0] REG_HALF_PERIOD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY_WAIT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE_WAIT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_EXIT_LOW    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY         = 3'd4;

  localparam logic [CFG_HALF_W-1:0] RST_HALF_PERIOD = 8'd1;
  localparam logic [CFG_WAIT_W-1:0] RST_ENTRY_WAIT  = 20'd2;
  localparam logic [CFG_WAIT_W-1:0] RST_SETTLE_WAIT = 20'd450;
  localparam logic [CFG_WAIT_W-1:0] RST_EXIT_LOW    = 20'd10;
  localparam logic [CFG_KEY_W-1:0]  RST_KEY         = 32'h4D43_4850;

  localparam logic [1:0] MODE_CMD   = 2'd0;
  localparam logic [1:0] MODE_ENTER = 2'd1;
  localparam logic [1:0] MODE_EXIT  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_CMD  = 2'd1;
  localparam logic [1:0] STAT_TOO_WIDE = 2'd2;

  localparam logic [3:0] CMD_CORE_INST      = 4'b0000;
  localparam logic [3:0] CMD_SHIFT_TABLAT   = 4'b0010;
  localparam logic [3:0] CMD_TBLRD          = 4'b1000;
  localparam logic [3:0] CMD_TBLRD_POSTINC  = 4'b1001;
  localparam logic [3:0] CMD_TBLRD_POSTDEC  = 4'b1010;
  localparam logic [3:0] CMD_TBLRD_PREINC   = 4'b1011;
  localparam logic [3:0] CMD_TBLWR          = 4'b1100;
  localparam logic [3:0] CMD_TBLWR_POSTINC2 = 4'b1101;
  localparam logic [3:0] CMD_TBLWR_PROG_INC = 4'b1110;
  localparam logic [3:0] CMD_TBLWR_PROG     = 4'b1111;

  typedef enum logic [4:0] {
    PH_IDLE, PH_E_LOW, PH_E_PULSE, PH_E_WAIT, PH_E_KLO, PH_E_KHI, PH_E_KEND,
    PH_E_SETTLE, PH_X_PRE, PH_X_LOW, PH_C_LO, PH_C_HI, PH_C_GAP, PH_C_TAIL,
    PH_R_REL, PH_R_HI, PH_R_LO, PH_R_END
  } phase_t;

  typedef struct packed {
    logic [CFG_HALF_W-1:0] half_period;
    logic [CFG_WAIT_W-1:0] entry_wait;
    logic [CFG_WAIT_W-1:0] settle_wait;
    logic [CFG_WAIT_W-1:0] exit_low;
    logic [CFG_KEY_W-1:0]  key;
  } cfg_t;

  typedef struct packed {
    logic       pgc;
    logic       pgd;
    logic       drive;
    logic       mclr;
    logic       busy;
    logic       done;
    logic [1:0] status;
    logic [7:0] read_data;
    logic       lvp;
  } res_t;

endpackage

[rtl/icsp_seq.sv]
`timescale 1ns / 1ps

module icsp_seq
  import icsp_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int WAIT_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        start_req,
  input  logic [1:0]  mode,
  input  logic [3:0]  cmd,
  input  logic [15:0] payload,
  input  logic        pgd_in,
  input  cfg_t        cfg,
  output res_t        res
);

  localparam int IDX_MAX = (KEY_BITS > WRITE_FRAME_BITS) ? KEY_BITS : WRITE_FRAME_BITS;
  localparam int IDX_W   = $clog2(IDX_MAX + 1);
  localparam logic [4:0] KEY_LAST = 5'(KEY_BITS - 1);

  phase_t                          phase, phase_next;
  logic [IDX_W-1:0]                bit_index, bit_index_next;
  logic [WAIT_WIDTH-1:0]           wait_count, wait_count_next;
  logic [WRITE_FRAME_BITS-1:0]     shift_out, shift_out_next;
  logic [READ_BITS-1:0]            read_shift, read_shift_next;
  logic                            lvp_flag, lvp_flag_next;
  logic                            pgc, pgc_next;
  logic                            pgd, pgd_next;
  logic                            drive, drive_next;
  logic                            mclr, mclr_next;
  logic                            is_read, is_read_next;
  logic [1:0]                      last_status, last_status_next;
  logic                            done_next;

  logic [WAIT_WIDTH-1:0] hp_raw, ew_raw, st_raw, xl_raw;
  logic [WAIT_WIDTH-1:0] hp_hold, ew_hold, st_hold, xl_hold;
  logic [IDX_W-1:0]      frame_bits;
  logic                  cmd_ok, cmd_rd;

  assign hp_raw  = WAIT_WIDTH'(cfg.half_period);
  assign ew_raw  = WAIT_WIDTH'(cfg.entry_wait);
  assign st_raw  = WAIT_WIDTH'(cfg.settle_wait);
  assign xl_raw  = WAIT_WIDTH'(cfg.exit_low);
  assign hp_hold = (hp_raw == '0) ? WAIT_WIDTH'(1) : hp_raw;
  assign ew_hold = (ew_raw == '0) ? WAIT_WIDTH'(1) : ew_raw;
  assign st_hold = (st_raw == '0) ? WAIT_WIDTH'(1) : st_raw;
  assign xl_hold = (xl_raw == '0) ? WAIT_WIDTH'(1) : xl_raw;

  assign frame_bits = is_read ? IDX_W'(READ_FRAME_BITS) : IDX_W'(WRITE_FRAME_BITS);

  always_comb begin
    cmd_ok = 1'b1;
    cmd_rd = 1'b0;
    unique case (cmd)
      CMD_CORE_INST, CMD_TBLWR, CMD_TBLWR_POSTINC2, CMD_TBLWR_PROG_INC,
      CMD_TBLWR_PROG: begin
        cmd_rd = 1'b0;
      end
      CMD_SHIFT_TABLAT, CMD_TBLRD, CMD_TBLRD_POSTINC, CMD_TBLRD_POSTDEC,
      CMD_TBLRD_PREINC: begin
        cmd_rd = 1'b1;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_index   <= '0;
      wait_count  <= '0;
      shift_out   <= '0;
      read_shift  <= '1;
      lvp_flag    <= 1'b0;
      pgc         <= 1'b0;
      pgd         <= 1'b0;
      drive       <= 1'b1;
      mclr        <= 1'b1;
      is_read     <= 1'b0;
      last_status <= STAT_OK;
    end else begin
      phase       <= phase_next;
      bit_index   <= bit_index_next;
      wait_count  <= wait_count_next;
      shift_out   <= shift_out_next;
      read_shift  <= read_shift_next;
      lvp_flag    <= lvp_flag_next;
      pgc         <= pgc_next;
      pgd         <= pgd_next;
      drive       <= drive_next;
      mclr        <= mclr_next;
      is_read     <= is_read_next;
      last_status <= last_status_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    bit_index_next   = bit_index;
    wait_count_next  = wait_count;
    shift_out_next   = shift_out;
    read_shift_next  = read_shift;
    lvp_flag_next    = lvp_flag;
    pgc_next         = pgc;
    pgd_next         = pgd;
    drive_next       = drive;
    mclr_next        = mclr;
    is_read_next     = is_read;
    last_status_next = last_status;
    done_next        = 1'b0;

    if (step) begin
      if (phase != PH_IDLE) begin
        if (wait_count > WAIT_WIDTH'(1)) begin
          wait_count_next = wait_count - WAIT_WIDTH'(1);
        end else begin
          unique case (phase)
            PH_E_LOW: begin
              mclr_next = 1'b1;
              wait_count_next = hp_hold;
              phase_next = PH_E_PULSE;
            end
            PH_E_PULSE: begin
              mclr_next = 1'b0;
              wait_count_next = ew_hold;
              phase_next = PH_E_WAIT;
            end
            PH_E_WAIT: begin
              bit_index_next = '0;
              pgc_next = 1'b0;
              pgd_next = cfg.key[KEY_LAST];
              wait_count_next = hp_hold;
              phase_next = PH_E_KLO;
            end
            PH_E_KLO: begin
              pgc_next = 1'b1;
              wait_count_next = hp_hold;
              bit_index_next = bit_index + IDX_W'(1);
              phase_next = PH_E_KHI;
            end
            PH_E_KHI: begin
              pgc_next = 1'b0;
              wait_count_next = hp_hold;
              if (bit_index < IDX_W'(KEY_BITS)) begin
                pgd_next = cfg.key[KEY_LAST - bit_index[4:0]];
                phase_next = PH_E_KLO;
              end else begin
                phase_next = PH_E_KEND;
              end
            end
            PH_E_KEND: begin
              mclr_next = 1'b1;
              wait_count_next = st_hold;
              phase_next = PH_E_SETTLE;
            end
            PH_E_SETTLE, PH_C_TAIL, PH_R_END: begin
              phase_next = PH_IDLE;
              last_status_next = STAT_OK;
              done_next = 1'b1;
            end
            PH_X_PRE: begin
              mclr_next = 1'b0;
              wait_count_next = xl_hold;
              phase_next = PH_X_LOW;
            end
            PH_X_LOW: begin
              mclr_next = 1'b1;
              phase_next = PH_IDLE;
              last_status_next = STAT_OK;
              done_next = 1'b1;
            end
            PH_C_LO: begin
              pgc_next = 1'b1;
              wait_count_next = hp_hold;
              bit_index_next = bit_index + IDX_W'(1);
              phase_next = PH_C_HI;
            end
            PH_C_HI: begin
              pgc_next = 1'b0;
              wait_count_next = hp_hold;
              if (bit_index == IDX_W'(CMD_BITS)) begin
                phase_next = PH_C_GAP;
              end else if (bit_index >= frame_bits) begin
                if (is_read) begin
                  drive_next = 1'b0;
                  bit_index_next = '0;
                  phase_next = PH_R_REL;
                end else begin
                  phase_next = PH_C_TAIL;
                end
              end else begin
                pgd_next = shift_out[bit_index[4:0]];
                phase_next = PH_C_LO;
              end
            end
            PH_C_GAP: begin
              pgc_next = 1'b0;
              pgd_next = shift_out[bit_index[4:0]];
              wait_count_next = hp_hold;
              phase_next = PH_C_LO;
            end
            PH_R_REL: begin
              pgc_next = 1'b1;
              wait_count_next = hp_hold;
              phase_next = PH_R_HI;
            end
            PH_R_HI: begin
              pgc_next = 1'b0;
              read_shift_next[bit_index[2:0]] = pgd_in;
              bit_index_next = bit_index + IDX_W'(1);
              wait_count_next = hp_hold;
              phase_next = PH_R_LO;
            end
            PH_R_LO: begin
              wait_count_next = hp_hold;
              if (bit_index < IDX_W'(READ_BITS)) begin
                pgc_next = 1'b1;
                phase_next = PH_R_HI;
              end else begin
                drive_next = 1'b1;
                phase_next = PH_R_END;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
      end else if (start_req) begin
        unique case (mode)
          MODE_CMD: begin
            if (!cmd_ok) begin
              last_status_next = STAT_BAD_CMD;
              done_next = 1'b1;
            end else if (cmd_rd && (payload[15:8] != 8'd0)) begin
              last_status_next = STAT_TOO_WIDE;
              done_next = 1'b1;
            end else begin
              is_read_next = cmd_rd;
              if (cmd_rd) begin
                read_shift_next = '1;
              end
              shift_out_next = {payload, cmd};
              bit_index_next = '0;
              pgc_next = 1'b0;
              pgd_next = cmd[0];
              wait_count_next = hp_hold;
              phase_next = PH_C_LO;
            end
          end
          MODE_ENTER: begin
            if (lvp_flag) begin
              last_status_next = STAT_OK;
              done_next = 1'b1;
            end else begin
              lvp_flag_next = 1'b1;
              mclr_next = 1'b0;
              pgd_next = 1'b0;
              pgc_next = 1'b0;
              wait_count_next = hp_hold;
              phase_next = PH_E_LOW;
            end
          end
          MODE_EXIT: begin
            lvp_flag_next = 1'b0;
            wait_count_next = hp_hold;
            phase_next = PH_X_PRE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.pgc       = pgc_next;
    res.pgd       = pgd_next;
    res.drive     = drive_next;
    res.mclr      = mclr_next;
    res.busy      = (phase_next != PH_IDLE);
    res.done      = done_next;
    res.status    = last_status_next;
    res.read_data = read_shift_next;
    res.lvp       = lvp_flag_next;
  end

endmodule

[rtl/icsp_lvp_serial_master.sv]
`timescale 1ns / 1ps
// A result is registered into the output register, or into the skid stage while the output is stalled.
// Throughput: one input transfer per cycle while in_stall is low, one result per input.
// Output register plus a one-entry skid stage; in_stall rises only when both are full.
// Reset (rst, synchronous, active high): sequencer idle with its pin state clock low, data
// low and driven, reset high; registers back to their defaults; output stages empty.

module icsp_lvp_serial_master
  import icsp_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int WAIT_WIDTH = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  start_req,
  input  logic [1:0]            mode,
  input  logic [3:0]            cmd,
  input  logic [15:0]           payload,
  input  logic                  pgd_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  pgc_level,
  output logic                  pgd_out,
  output logic                  pgd_drive,
  output logic                  mclr_level,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [1:0]            status,
  output logic [7:0]            read_data,
  output logic                  in_lvp_mode,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t                 cfg;
  res_t                 res_step;
  res_t                 res_out;
  res_t                 res_skid;
  logic                 skid_valid;
  logic                 accept;
  logic                 take;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period <= RST_HALF_PERIOD;
      cfg.entry_wait  <= RST_ENTRY_WAIT;
      cfg.settle_wait <= RST_SETTLE_WAIT;
      cfg.exit_low    <= RST_EXIT_LOW;
      cfg.key         <= RST_KEY;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HALF_PERIOD: cfg.half_period <= pwdata[CFG_HALF_W-1:0];
        REG_ENTRY_WAIT:  cfg.entry_wait  <= pwdata[CFG_WAIT_W-1:0];
        REG_SETTLE_WAIT: cfg.settle_wait <= pwdata[CFG_WAIT_W-1:0];
        REG_EXIT_LOW:    cfg.exit_low    <= pwdata[CFG_WAIT_W-1:0];
        REG_KEY:         cfg.key         <= pwdata[CFG_KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HALF_PERIOD: prdata = APB_DATA_W'(cfg.half_period);
      REG_ENTRY_WAIT:  prdata = APB_DATA_W'(cfg.entry_wait);
      REG_SETTLE_WAIT: prdata = APB_DATA_W'(cfg.settle_wait);
      REG_EXIT_LOW:    prdata = APB_DATA_W'(cfg.exit_low);
      REG_KEY:         prdata = APB_DATA_W'(cfg.key);
      default:         prdata = '0;
    endcase
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  icsp_seq #(
    .KEY_BITS   (KEY_BITS),
    .WAIT_WIDTH (WAIT_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .start_req (start_req),
    .mode      (mode),
    .cmd       (cmd),
    .payload   (payload),
    .pgd_in    (pgd_in),
    .cfg       (cfg),
    .res       (res_step)
  );

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      res_out <= skid_valid ? res_skid : res_step;
    end
    if (out_valid && !take && accept) begin
      res_skid <= res_step;
    end
  end

  assign pgc_level   = res_out.pgc;
  assign pgd_out     = res_out.pgd;
  assign pgd_drive   = res_out.drive;
  assign mclr_level  = res_out.mclr;
  assign busy_res    = res_out.busy;
  assign done_res    = res_out.done;
  assign status      = res_out.status;
  assign read_data   = res_out.read_data;
  assign in_lvp_mode = res_out.lvp;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && accept) |=> skid_valid)
    else $error("transfer under output stall not held in skid stage");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> !skid_valid)
    else $error("skid stage did not drain");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res_out.busy && res_out.done))
    else $error("done reported while still busy");

  a_idle_mclr_high: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_out.busy) |-> res_out.mclr)
    else $error("target held in reset while idle");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import icsp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 200;
  localparam logic [15:0] READ_MAX = 16'h00FF;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [3:0] CMD_UNUSED_LO = 4'd1;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd7;

  typedef enum logic [1:0] {CK_WRITE, CK_READ, CK_BAD} cmd_kind_t;

  typedef struct packed {
    logic        start;
    logic [1:0]  mode;
    logic [3:0]  cmd;
    logic [15:0] payload;
    logic        din;
  } tick_t;

  typedef struct packed {
    tick_t item;
    logic  typed;
    res_t  want;
  } op_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic start_req = 1'b0;
  logic [1:0] mode = MODE_CMD;
  logic [3:0] cmd = CMD_CORE_INST;
  logic [15:0] payload = '0;
  logic pgd_in = 1'b0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;

  logic in_stall, out_valid;
  logic pgc_level, pgd_out, pgd_drive, mclr_level, busy_res, done_res, in_lvp_mode;
  logic [1:0] status;
  logic [7:0] read_data;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  icsp_lvp_serial_master dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_req(start_req), .mode(mode), .cmd(cmd), .payload(payload), .pgd_in(pgd_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .pgc_level(pgc_level), .pgd_out(pgd_out), .pgd_drive(pgd_drive),
    .mclr_level(mclr_level), .busy_res(busy_res), .done_res(done_res),
    .status(status), .read_data(read_data), .in_lvp_mode(in_lvp_mode),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sequencer shadow
  logic [CFG_HALF_W-1:0] half_ticks = RST_HALF_PERIOD;
  logic [CFG_WAIT_W-1:0] entry_ticks = RST_ENTRY_WAIT;
  logic [CFG_WAIT_W-1:0] settle_ticks = RST_SETTLE_WAIT;
  logic [CFG_WAIT_W-1:0] exit_ticks = RST_EXIT_LOW;
  logic [CFG_KEY_W-1:0] key_word = RST_KEY;

  phase_t seq_phase = PH_IDLE;
  int unsigned bit_pos = 0;
  int unsigned hold_left = 0;
  logic [31:0] shift_word = '0;
  logic [7:0] rd_byte = 8'hFF;
  logic lvp_q = 1'b0;
  logic pgc_q = 1'b0, pgd_q = 1'b0, drv_q = 1'b1, mclr_q = 1'b1;
  logic rd_kind = 1'b0;
  logic seq_done = 1'b0;
  logic [1:0] last_stat = STAT_OK;

  res_t pins_due[$];
  int mismatches = 0;
  int sent = 0;
  int quiet = 0;
  int tx_idle_pct = 15;
  int rx_stall_pct = 59;

  function automatic cmd_kind_t cmd_kind(logic [3:0] c);
    case (c)
      CMD_CORE_INST, CMD_TBLWR, CMD_TBLWR_POSTINC2, CMD_TBLWR_PROG_INC,
      CMD_TBLWR_PROG: return CK_WRITE;
      CMD_SHIFT_TABLAT, CMD_TBLRD, CMD_TBLRD_POSTINC, CMD_TBLRD_POSTDEC,
      CMD_TBLRD_PREINC: return CK_READ;
      default: return CK_BAD;
    endcase
  endfunction

  function automatic void arm(logic [CFG_WAIT_W-1:0] n);
    hold_left = (n == 0) ? 1 : n;
  endfunction

  function automatic void end_op(logic [1:0] st);
    seq_phase = PH_IDLE;
    last_stat = st;
    seq_done = 1'b1;
  endfunction

  function automatic void key_bit();
    pgc_q = 1'b0;
    pgd_q = key_word[CFG_KEY_W - 1 - bit_pos];
    arm(half_ticks);
    seq_phase = PH_E_KLO;
  endfunction

  function automatic void cmd_bit();
    pgc_q = 1'b0;
    pgd_q = shift_word[bit_pos];
    arm(half_ticks);
    seq_phase = PH_C_LO;
  endfunction

  function automatic res_t sequencer_tick(tick_t t);
    int unsigned frame_len;
    cmd_kind_t kind;
    seq_done = 1'b0;
    frame_len = rd_kind ? READ_FRAME_BITS : WRITE_FRAME_BITS;
    if (seq_phase != PH_IDLE) begin
      if (hold_left > 1) begin
        hold_left--;
      end else begin
        case (seq_phase)
          PH_E_LOW: begin
            mclr_q = 1'b1; arm(half_ticks); seq_phase = PH_E_PULSE;
          end
          PH_E_PULSE: begin
            mclr_q = 1'b0; arm(entry_ticks); seq_phase = PH_E_WAIT;
          end
          PH_E_WAIT: begin
            bit_pos = 0; key_bit();
          end
          PH_E_KLO: begin
            pgc_q = 1'b1; arm(half_ticks); bit_pos++; seq_phase = PH_E_KHI;
          end
          PH_E_KHI: begin
            if (bit_pos < CFG_KEY_W) begin
              key_bit();
            end else begin
              pgc_q = 1'b0; arm(half_ticks); seq_phase = PH_E_KEND;
            end
          end
          PH_E_KEND: begin
            mclr_q = 1'b1; arm(settle_ticks); seq_phase = PH_E_SETTLE;
          end
          PH_E_SETTLE: end_op(STAT_OK);
          PH_X_PRE: begin
            mclr_q = 1'b0; arm(exit_ticks); seq_phase = PH_X_LOW;
          end
          PH_X_LOW: begin
            mclr_q = 1'b1; end_op(STAT_OK);
          end
          PH_C_LO: begin
            pgc_q = 1'b1; arm(half_ticks); bit_pos++; seq_phase = PH_C_HI;
          end
          PH_C_HI: begin
            if (bit_pos == CMD_BITS) begin
              pgc_q = 1'b0; arm(half_ticks); seq_phase = PH_C_GAP;
            end else if (bit_pos >= frame_len) begin
              pgc_q = 1'b0;
              arm(half_ticks);
              if (rd_kind) begin
                drv_q = 1'b0; bit_pos = 0; seq_phase = PH_R_REL;
              end else begin
                seq_phase = PH_C_TAIL;
              end
            end else begin
              cmd_bit();
            end
          end
          PH_C_GAP: cmd_bit();
          PH_C_TAIL: end_op(STAT_OK);
          PH_R_REL: begin
            pgc_q = 1'b1; arm(half_ticks); seq_phase = PH_R_HI;
          end
          PH_R_HI: begin
            pgc_q = 1'b0;
            rd_byte[bit_pos % 8] = t.din;
            bit_pos++;
            arm(half_ticks);
            seq_phase = PH_R_LO;
          end
          PH_R_LO: begin
            if (bit_pos < READ_BITS) begin
              pgc_q = 1'b1; arm(half_ticks); seq_phase = PH_R_HI;
            end else begin
              drv_q = 1'b1; arm(half_ticks); seq_phase = PH_R_END;
            end
          end
          PH_R_END: end_op(STAT_OK);
          default: seq_phase = PH_IDLE;
        endcase
      end
    end else if (t.start) begin
      case (t.mode)
        MODE_CMD: begin
          kind = cmd_kind(t.cmd);
          if (kind == CK_BAD) begin
            end_op(STAT_BAD_CMD);
          end else if (kind == CK_READ && t.payload > READ_MAX) begin
            end_op(STAT_TOO_WIDE);
          end else begin
            rd_kind = (kind == CK_READ);
            if (rd_kind) rd_byte = 8'hFF;
            shift_word = {12'd0, t.payload, t.cmd};
            bit_pos = 0;
            cmd_bit();
          end
        end
        MODE_ENTER: begin
          if (lvp_q) begin
            end_op(STAT_OK);
          end else begin
            lvp_q = 1'b1;
            mclr_q = 1'b0; pgd_q = 1'b0; pgc_q = 1'b0;
            arm(half_ticks);
            seq_phase = PH_E_LOW;
          end
        end
        MODE_EXIT: begin
          lvp_q = 1'b0;
          arm(half_ticks);
          seq_phase = PH_X_PRE;
        end
        default: ;
      endcase
    end
    return '{pgc_q, pgd_q, drv_q, mclr_q, seq_phase != PH_IDLE, seq_done, last_stat,
             rd_byte, lvp_q};
  endfunction

  function automatic res_t pins_idle(logic done, logic [1:0] st);
    return '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, done, st, 8'hFF, 1'b0};
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.start = 1'($urandom_range(1));
    t.mode = 2'($urandom_range(3));
    t.cmd = 4'($urandom_range(15));
    t.payload = 16'($urandom_range(65535));
    t.din = 1'($urandom_range(1));
    return t;
  endfunction

  function automatic logic [3:0] pick_cmd(cmd_kind_t kind);
    logic [3:0] c;
    do c = 4'($urandom_range(15)); while (cmd_kind(c) != kind);
    return c;
  endfunction

  task automatic send_tick(tick_t t, logic typed, res_t want);
    res_t r;
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_req <= t.start;
    mode <= t.mode;
    cmd <= t.cmd;
    payload <= t.payload;
    pgd_in <= t.din;
    do @(posedge clk); while (in_stall);
    r = sequencer_tick(t);
    pins_due.push_back(typed ? want : r);
    sent++;
  endtask

  // one operation: the start transfer, then ticks until the sequencer is idle
  task automatic run_op(tick_t t, logic typed, res_t want);
    send_tick(t, typed, want);
    while (seq_phase != PH_IDLE) send_tick(random_tick(), 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_HALF_PERIOD: half_ticks = val[CFG_HALF_W-1:0];
      REG_ENTRY_WAIT:  entry_ticks = val[CFG_WAIT_W-1:0];
      REG_SETTLE_WAIT: settle_ticks = val[CFG_WAIT_W-1:0];
      REG_EXIT_LOW:    exit_ticks = val[CFG_WAIT_W-1:0];
      REG_KEY:         key_word = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(logic [31:0] h, logic [31:0] e, logic [31:0] s,
                           logic [31:0] x, logic [31:0] k);
    write_reg(REG_HALF_PERIOD, h);
    write_reg(REG_ENTRY_WAIT, e);
    write_reg(REG_SETTLE_WAIT, s);
    write_reg(REG_EXIT_LOW, x);
    write_reg(REG_KEY, k);
  endtask

  task automatic random_op();
    tick_t t;
    int sel;
    t = random_tick();
    t.start = 1'b1;
    sel = $urandom_range(99);
    if (sel < 22) begin
      t.mode = MODE_CMD; t.cmd = pick_cmd(CK_WRITE);
    end else if (sel < 45) begin
      t.mode = MODE_CMD; t.cmd = pick_cmd(CK_READ); t.payload = 16'($urandom_range(255));
    end else if (sel < 58) begin
      t.mode = MODE_ENTER;
    end else if (sel < 70) begin
      t.mode = MODE_EXIT;
    end else if (sel < 78) begin
      t.mode = MODE_CMD; t.cmd = pick_cmd(CK_BAD);
    end else if (sel < 86) begin
      t.mode = MODE_CMD; t.cmd = pick_cmd(CK_READ);
      t.payload = 16'($urandom_range(65535, 256));
    end else if (sel < 92) begin
      t.mode = MODE_NONE;
    end else begin
      t.start = 1'b0;
    end
    run_op(t, 1'b0, '0);
    if ($urandom_range(24) == 0) drain_results();
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pins_due.size() == 0) begin
        mismatches++;
        $error("result transfer with nothing expected");
      end else begin
        want = pins_due.pop_front();
        check_field("pgc_level", 8'(want.pgc), 8'(pgc_level));
        check_field("pgd_out", 8'(want.pgd), 8'(pgd_out));
        check_field("pgd_drive", 8'(want.drive), 8'(pgd_drive));
        check_field("mclr_level", 8'(want.mclr), 8'(mclr_level));
        check_field("busy_res", 8'(want.busy), 8'(busy_res));
        check_field("done_res", 8'(want.done), 8'(done_res));
        check_field("status", 8'(want.status), 8'(status));
        check_field("read_data", want.read_data, read_data);
        check_field("in_lvp_mode", 8'(want.lvp), 8'(in_lvp_mode));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    op_row_t rows[$];
    op_row_t row;
    tick_t t;
    int base;

    rows.push_back('{'{1'b0, MODE_CMD, CMD_CORE_INST, 16'h0000, 1'b0}, 1'b1,
                     pins_idle(1'b0, STAT_OK)});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_UNUSED_LO, 16'h0000, 1'b0}, 1'b1,
                     pins_idle(1'b1, STAT_BAD_CMD)});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_UNUSED_HI, 16'hFFFF, 1'b0}, 1'b1,
                     pins_idle(1'b1, STAT_BAD_CMD)});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_SHIFT_TABLAT, 16'h0100, 1'b0}, 1'b1,
                     pins_idle(1'b1, STAT_TOO_WIDE)});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_TBLRD_PREINC, 16'hFFFF, 1'b0}, 1'b1,
                     pins_idle(1'b1, STAT_TOO_WIDE)});
    rows.push_back('{'{1'b1, MODE_NONE, CMD_CORE_INST, 16'h0000, 1'b0}, 1'b1,
                     pins_idle(1'b0, STAT_TOO_WIDE)});
    rows.push_back('{'{1'b1, MODE_EXIT, CMD_CORE_INST, 16'h0000, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_CORE_INST, 16'h0000, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_TBLWR, 16'hFFFF, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_TBLWR_POSTINC2, 16'hA5C3, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_TBLWR_PROG_INC, 16'h5A3C, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_TBLWR_PROG, 16'h0001, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_SHIFT_TABLAT, 16'h0000, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_TBLRD, 16'h00FF, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_TBLRD_POSTINC, 16'h0080, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_TBLRD_POSTDEC, 16'h0001, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_CMD, CMD_TBLRD_PREINC, 16'h00FF, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_ENTER, CMD_CORE_INST, 16'h0000, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_ENTER, CMD_TBLWR, 16'h1234, 1'b0}, 1'b0, '0});
    rows.push_back('{'{1'b1, MODE_EXIT, CMD_CORE_INST, 16'h0000, 1'b0}, 1'b0, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      row.item.din = 1'($urandom_range(1));
      run_op(row.item, row.typed, row.want);
    end
    drain_results();

    apply_cfg(32'd1, 32'd1, 32'd3, 32'd1, $urandom);
    base = sent;
    while (sent - base < PHASE_ITEMS) random_op();
    drain_results();

    // zero in a wait register counts as one tick
    tx_idle_pct = 59;
    rx_stall_pct = 15;
    apply_cfg(32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_0000);
    base = sent;
    while (sent - base < PHASE_ITEMS) random_op();
    drain_results();

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    apply_cfg(32'd2, 32'hF_FFFF, 32'hF_FFFF, 32'hF_FFFF, $urandom);
    t = random_tick();
    t.start = 1'b1;
    t.mode = MODE_CMD;
    t.cmd = CMD_TBLWR;
    run_op(t, 1'b0, '0);
    t = random_tick();
    t.start = 1'b1;
    t.mode = MODE_CMD;
    t.cmd = CMD_TBLRD;
    t.payload = 16'($urandom_range(255));
    run_op(t, 1'b0, '0);
    drain_results();

    apply_cfg(32'd3, 32'd5, 32'd7, 32'd4, 32'hFFFF_FFFF);
    base = sent;
    while (sent - base < PHASE_ITEMS) random_op();

    in_valid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/icsp_pkg.sv
rtl/icsp_seq.sv
rtl/icsp_lvp_serial_master.sv
tb/sv/tb.sv
